// ===== hdl/lsal_pkg.sv =====
package lsal_pkg;

  localparam int CNT_W   = 16;
  localparam int LUX_W   = 40;
  localparam int COEF_W  = 16;
  localparam int K_W     = 32;
  localparam int PROD_W  = COEF_W + K_W;
  localparam int DEN_W   = 23;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [1:0] STATUS_WAIT   = 2'd0;
  localparam logic [1:0] STATUS_READJ  = 2'd1;
  localparam logic [1:0] STATUS_RESULT = 2'd2;
  localparam logic [1:0] STATUS_ABORT  = 2'd3;

  localparam logic [1:0] CFG_AUTO_MODE    = 2'd0;
  localparam logic [1:0] CFG_START_GAIN   = 2'd1;
  localparam logic [1:0] CFG_START_TIME   = 2'd2;
  localparam logic [1:0] CFG_GLASS_FACTOR = 2'd3;

  localparam logic       ACT_START  = 1'b0;
  localparam logic       GAIN_1X    = 1'b0;
  localparam logic       GAIN_150X  = 1'b1;

  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_MID  = 2'd1;
  localparam logic [1:0] REG_HIGH = 2'd2;
  localparam logic [1:0] REG_NONE = 2'd3;

  localparam logic [CNT_W-1:0] CNT_SAT      = 16'hFFFF;
  localparam logic [CNT_W-1:0] IR_FIX_MIN   = 16'd1000;
  localparam logic [CNT_W-1:0] UP_THR_1X    = 16'd100;
  localparam logic [CNT_W-1:0] UP_THR_150X  = 16'd2000;
  localparam logic [CNT_W-1:0] DOWN_THR     = 16'd25000;
  localparam logic [LUX_W-1:0] LUX_UP_MIN   = 40'd81920;
  localparam logic [16:0]      GLASS_RESET  = 17'd256;

  localparam logic [2:0] LADDER_LAST = 3'd4;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } lsal_lpos_t;

  function automatic logic [DEN_W-1:0] lsal_den(input logic gain, input logic [1:0] tcode);
    logic [DEN_W-1:0] d;
    unique case ({gain, tcode})
      3'b000:  d = 23'd10000;
      3'b001:  d = 23'd5000;
      3'b010:  d = 23'd20000;
      3'b011:  d = 23'd40000;
      3'b100:  d = 23'd1500000;
      3'b101:  d = 23'd750000;
      3'b110:  d = 23'd3000000;
      default: d = 23'd6000000;
    endcase
    return d;
  endfunction

  function automatic logic [COEF_W-1:0] lsal_coef_a(input logic [1:0] region);
    logic [COEF_W-1:0] c;
    unique case (region)
      REG_LOW:  c = 16'd17743;
      REG_MID:  c = 16'd37725;
      REG_HIGH: c = 16'd16903;
      default:  c = 16'd0;
    endcase
    return c;
  endfunction

  function automatic logic [COEF_W-1:0] lsal_coef_b(input logic [1:0] region);
    logic [COEF_W-1:0] c;
    unique case (region)
      REG_LOW:  c = 16'd11059;
      REG_MID:  c = 16'd13363;
      REG_HIGH: c = 16'd1693;
      default:  c = 16'd0;
    endcase
    return c;
  endfunction

  function automatic lsal_lpos_t lsal_ladder_pos(input logic gain, input logic [1:0] tcode);
    lsal_lpos_t p;
    p.hit = 1'b1;
    unique case ({gain, tcode})
      3'b001:  p.idx = 3'd0;
      3'b000:  p.idx = 3'd1;
      3'b100:  p.idx = 3'd2;
      3'b110:  p.idx = 3'd3;
      3'b111:  p.idx = 3'd4;
      default: begin
        p.hit = 1'b0;
        p.idx = 3'd0;
      end
    endcase
    return p;
  endfunction

  function automatic logic lsal_ladder_gain(input logic [2:0] idx);
    return (idx >= 3'd2) ? GAIN_150X : GAIN_1X;
  endfunction

  function automatic logic [1:0] lsal_ladder_time(input logic [2:0] idx);
    logic [1:0] t;
    unique case (idx)
      3'd0:    t = 2'd1;
      3'd1:    t = 2'd0;
      3'd2:    t = 2'd0;
      3'd3:    t = 2'd2;
      default: t = 2'd3;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/lsal_if.sv =====
interface lsal_in_if import lsal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic             new_data;
  logic             reported_gain;
  logic [CNT_W-1:0] visible_count;
  logic [CNT_W-1:0] infrared_count;

  modport source (
    output valid, action, new_data, reported_gain, visible_count, infrared_count,
    input  ready
  );
  modport sink (
    input  valid, action, new_data, reported_gain, visible_count, infrared_count,
    output ready
  );
endinterface

interface lsal_out_if import lsal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [LUX_W-1:0] lux_q8;
  logic [CNT_W-1:0] visible_out;
  logic [CNT_W-1:0] infrared_out;
  logic             gain_code;
  logic [1:0]       time_code;

  modport source (
    output valid, status, lux_q8, visible_out, infrared_out, gain_code, time_code,
    input  ready
  );
  modport sink (
    input  valid, status, lux_q8, visible_out, infrared_out, gain_code, time_code,
    output ready
  );
endinterface

// ===== hdl/lsal_div.sv =====
module lsal_div import lsal_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [DEN_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [PROD_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0]    quo_q, quo_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [DEN_W:0]       trial;
  logic                 ge;

  always_comb begin
    trial  = {rem_q, quo_q[PROD_W-1]};
    ge     = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      // shift one quotient bit in per cycle
      rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d = {quo_q[PROD_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hdl/light_sensor_autorange_lux_top.sv =====
// A start word, an ignored word or a failed sample gives its result word in the
// cycle after it is accepted; a good sample goes through S_REGION, S_MULA, S_MULB,
// S_MULG, S_DIV (bit-serial divider, 48 steps, behind the shared 16x32 multiplier)
// and S_DEC. No new word is taken while a good sample is in work or the result slot is full.
// Reset (async, active low) clears phase, gain/time, counters and output valid,
// and loads the configuration defaults (glass factor 1.0).
module light_sensor_autorange_lux_top import lsal_pkg::*; #(
  parameter int MAX_RETRIES = 5,
  parameter int MAX_ADJUST  = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsal_in_if.sink     in_ch,
  lsal_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REGION = 3'd1;
  localparam logic [2:0] S_MULA   = 3'd2;
  localparam logic [2:0] S_MULB   = 3'd3;
  localparam logic [2:0] S_MULG   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DEC    = 3'd6;

  logic [2:0] state_q, state_d;

  logic       auto_q, sgain_q;
  logic [1:0] stime_q;
  logic [15:0] glass_q;

  logic       phase_q, phase_d;
  logic       gain_q, gain_d;
  logic [1:0] time_q, time_d;
  logic [3:0] adj_q, adj_d;
  logic [2:0] retry_q, retry_d;

  logic [CNT_W-1:0] c0_q, c0_d, c1_q, c1_d;
  logic [1:0]       region_q, region_d;
  logic             kzero_q, kzero_d;
  logic [K_W-1:0]   a_q, a_d, k_q, k_d;
  logic [LUX_W-1:0] lux_q, lux_d;

  logic             out_vld_q, out_vld_d;
  logic [1:0]       o_status_q, o_status_d;
  logic [LUX_W-1:0] o_lux_q, o_lux_d;
  logic [CNT_W-1:0] o_vis_q, o_vis_d, o_ir_q, o_ir_d;
  logic             o_gain_q, o_gain_d;
  logic [1:0]       o_time_q, o_time_d;

  logic              out_free, in_acc;
  logic [COEF_W-1:0] mul_a;
  logic [K_W-1:0]    mul_b;
  logic [PROD_W-1:0] prod;
  logic              div_start, div_done;
  logic [PROD_W-1:0] div_quot;

  logic [16:0] sum17;
  logic [23:0] lhs, r45, r64, r85;
  logic [K_W-1:0] b_val;
  logic [CNT_W-1:0] fix0, fix1, up_thr;
  logic step_up, step_dn, do_step, early_final;
  logic [2:0] nidx;
  lsal_lpos_t lpos;
  logic [3:0] adj_inc;

  assign out_free    = !out_vld_q || out_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // shared multiplier
  always_comb begin
    unique case (state_q)
      S_MULA: begin
        mul_a = lsal_coef_a(region_q);
        mul_b = K_W'(c0_q);
      end
      S_MULB: begin
        mul_a = lsal_coef_b(region_q);
        mul_b = K_W'(c1_q);
      end
      S_MULG: begin
        mul_a = glass_q;
        mul_b = k_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign div_start = (state_q == S_MULG);

  lsal_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (lsal_den(gain_q, time_q)),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    sum17 = {1'b0, c0_q} + {1'b0, c1_q};
    lhs   = 24'(c1_q) * 24'd100;
    r45   = 24'(sum17) * 24'd45;
    r64   = 24'(sum17) * 24'd64;
    r85   = 24'(sum17) * 24'd85;
    b_val = prod[K_W-1:0];

    fix0 = c0_q;
    fix1 = c1_q;
    if (gain_q == GAIN_150X && c0_q == '0) begin
      if (c1_q == CNT_W'(1)) begin
        fix0 = CNT_SAT;
        fix1 = CNT_SAT;
      end else if (c1_q > IR_FIX_MIN) begin
        fix0 = CNT_SAT;
      end
    end
    up_thr  = (gain_q == GAIN_150X) ? UP_THR_150X : UP_THR_1X;
    step_up = (fix0 <= up_thr) || (gain_q == GAIN_1X && lux_q < LUX_UP_MIN);
    step_dn = (fix0 >= DOWN_THR) || (fix1 >= DOWN_THR);
    lpos    = lsal_ladder_pos(gain_q, time_q);
    do_step = 1'b0;
    nidx    = lpos.idx;
    if (step_up) begin
      if (lpos.hit && lpos.idx < LADDER_LAST) begin
        do_step = 1'b1;
        nidx    = lpos.idx + 3'd1;
      end
    end else if (step_dn) begin
      if (lpos.hit && lpos.idx != 3'd0) begin
        do_step = 1'b1;
        nidx    = lpos.idx - 3'd1;
      end
    end
    early_final = !auto_q || (adj_q > 4'(MAX_ADJUST));
    adj_inc     = (adj_q != 4'hF) ? adj_q + 4'd1 : adj_q;
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    gain_d   = gain_q;
    time_d   = time_q;
    adj_d    = adj_q;
    retry_d  = retry_q;
    c0_d     = c0_q;
    c1_d     = c1_q;
    region_d = region_q;
    kzero_d  = kzero_q;
    a_d      = a_q;
    k_d      = k_q;
    lux_d    = lux_q;

    out_vld_d  = out_vld_q && !out_ch.ready;
    o_status_d = o_status_q;
    o_lux_d    = o_lux_q;
    o_vis_d    = o_vis_q;
    o_ir_d     = o_ir_q;
    o_gain_d   = o_gain_q;
    o_time_d   = o_time_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_vld_d  = 1'b1;
          o_status_d = STATUS_WAIT;
          o_lux_d    = '0;
          o_vis_d    = '0;
          o_ir_d     = '0;
          o_gain_d   = gain_q;
          o_time_d   = time_q;
          if (in_ch.action == ACT_START) begin
            if (!phase_q) begin
              phase_d    = 1'b1;
              gain_d     = sgain_q;
              time_d     = stime_q;
              adj_d      = '0;
              o_gain_d   = sgain_q;
              o_time_d   = stime_q;
              o_status_d = auto_q ? STATUS_READJ : STATUS_WAIT;
            end
          end else if (phase_q) begin
            if (!in_ch.new_data || in_ch.reported_gain != gain_q) begin
              if (retry_q >= 3'(MAX_RETRIES)) begin
                retry_d    = '0;
                phase_d    = 1'b0;
                o_status_d = STATUS_ABORT;
              end else begin
                retry_d = retry_q + 3'd1;
              end
            end else begin
              // good sample: hold the word back until the lux is ready
              out_vld_d = out_vld_q && !out_ch.ready;
              o_status_d = o_status_q;
              o_lux_d    = o_lux_q;
              o_vis_d    = o_vis_q;
              o_ir_d     = o_ir_q;
              o_gain_d   = o_gain_q;
              o_time_d   = o_time_q;
              retry_d    = '0;
              c0_d       = in_ch.visible_count;
              c1_d       = in_ch.infrared_count;
              state_d    = S_REGION;
            end
          end
        end
      end
      S_REGION: begin
        kzero_d = (c0_q == CNT_SAT) || (c1_q == CNT_SAT) ||
                  (c0_q == '0 && c1_q == '0);
        if (lhs < r45) begin
          region_d = REG_LOW;
        end else if (lhs < r64) begin
          region_d = REG_MID;
        end else if (lhs < r85) begin
          region_d = REG_HIGH;
        end else begin
          region_d = REG_NONE;
        end
        state_d = S_MULA;
      end
      S_MULA: begin
        a_d     = prod[K_W-1:0];
        state_d = S_MULB;
      end
      S_MULB: begin
        if (kzero_q || region_q == REG_NONE) begin
          k_d = '0;
        end else if (region_q == REG_LOW) begin
          k_d = a_q + b_val;
        end else begin
          k_d = (a_q > b_val) ? a_q - b_val : '0;
        end
        state_d = S_MULG;
      end
      S_MULG: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          lux_d   = div_quot[LUX_W-1:0];
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          o_lux_d    = lux_q;
          o_status_d = STATUS_RESULT;
          state_d    = S_IDLE;
          phase_d    = 1'b0;
          if (auto_q) begin
            adj_d = adj_inc;
          end
          if (early_final) begin
            o_vis_d = c0_q;
            o_ir_d  = c1_q;
            o_gain_d = gain_q;
            o_time_d = time_q;
          end else begin
            o_vis_d  = fix0;
            o_ir_d   = fix1;
            o_gain_d = gain_q;
            o_time_d = time_q;
            if (do_step) begin
              phase_d    = 1'b1;
              gain_d     = lsal_ladder_gain(nidx);
              time_d     = lsal_ladder_time(nidx);
              o_gain_d   = lsal_ladder_gain(nidx);
              o_time_d   = lsal_ladder_time(nidx);
              o_status_d = STATUS_READJ;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= 1'b0;
      gain_q    <= GAIN_1X;
      time_q    <= '0;
      adj_q     <= '0;
      retry_q   <= '0;
      out_vld_q <= 1'b0;
      auto_q    <= 1'b0;
      sgain_q   <= GAIN_1X;
      stime_q   <= '0;
      glass_q   <= GLASS_RESET[15:0];
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      gain_q    <= gain_d;
      time_q    <= time_d;
      adj_q     <= adj_d;
      retry_q   <= retry_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_AUTO_MODE:    auto_q  <= cfg_data_i[0];
          CFG_START_GAIN:   sgain_q <= cfg_data_i[0];
          CFG_START_TIME:   stime_q <= cfg_data_i[1:0];
          CFG_GLASS_FACTOR: glass_q <= cfg_data_i;
          default:          auto_q  <= auto_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c0_q       <= c0_d;
    c1_q       <= c1_d;
    region_q   <= region_d;
    kzero_q    <= kzero_d;
    a_q        <= a_d;
    k_q        <= k_d;
    lux_q      <= lux_d;
    o_status_q <= o_status_d;
    o_lux_q    <= o_lux_d;
    o_vis_q    <= o_vis_d;
    o_ir_q     <= o_ir_d;
    o_gain_q   <= o_gain_d;
    o_time_q   <= o_time_d;
  end

  assign out_ch.valid        = out_vld_q;
  assign out_ch.status       = o_status_q;
  assign out_ch.lux_q8       = o_lux_q;
  assign out_ch.visible_out  = o_vis_q;
  assign out_ch.infrared_out = o_ir_q;
  assign out_ch.gain_code    = o_gain_q;
  assign out_ch.time_code    = o_time_q;

endmodule

// ===== hdl/lsal_chk.sv =====
module lsal_chk import lsal_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [1:0]       status_i,
  input logic [LUX_W-1:0] lux_q8_i,
  input logic [CNT_W-1:0] visible_out_i,
  input logic [CNT_W-1:0] infrared_out_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("input word taken while result slot full");

  a_quiet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STATUS_WAIT || status_i == STATUS_ABORT) |->
      lux_q8_i == '0 && visible_out_i == '0 && infrared_out_i == '0)
    else $error("waiting or abort word carries data");

  a_sat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (visible_out_i == CNT_SAT || infrared_out_i == CNT_SAT) |->
      lux_q8_i == '0)
    else $error("saturated counts with nonzero lux");

endmodule

bind light_sensor_autorange_lux_top lsal_chk u_lsal_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch.valid),
  .in_ready_i     (in_ch.ready),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .status_i       (out_ch.status),
  .lux_q8_i       (out_ch.lux_q8),
  .visible_out_i  (out_ch.visible_out),
  .infrared_out_i (out_ch.infrared_out)
);

// ===== sim/testbench.sv =====
module testbench;
  import lsal_pkg::*;

  localparam int MAX_RETRIES = 5;
  localparam int MAX_ADJUST  = 10;
  localparam int RAND_WORDS  = 1850;
  localparam int CFG_SPAN    = 200;

  localparam logic       ACT_SAMPLE = ~ACT_START;
  localparam logic [1:0] T_100MS = 2'd0;
  localparam logic [1:0] T_50MS  = 2'd1;
  localparam logic [1:0] T_200MS = 2'd2;
  localparam logic [1:0] T_400MS = 2'd3;

  localparam int         LADDER_RUNGS = 5;
  localparam logic [4:0] LADDER_GAIN  = {GAIN_150X, GAIN_150X, GAIN_150X, GAIN_1X, GAIN_1X};
  localparam logic [9:0] LADDER_TIME  = {T_400MS, T_200MS, T_100MS, T_100MS, T_50MS};

  typedef struct packed {
    logic        auto_on;
    logic        gain;
    logic [1:0]  tcode;
    logic [15:0] glass;
  } range_cfg_t;

  typedef struct packed {
    logic        action;
    logic        new_data;
    logic        rgain;
    logic [15:0] vis;
    logic [15:0] ir;
  } sensor_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [39:0] lux;
    logic [15:0] vis;
    logic [15:0] ir;
    logic        gain;
    logic [1:0]  tcode;
  } lux_word_t;

  typedef struct packed {
    logic         load_cfg;
    range_cfg_t   cfg;
    sensor_word_t word;
    logic         typed;
    lux_word_t    want;
  } step_row_t;

  localparam range_cfg_t   KEEP_CFG   = '0;
  localparam lux_word_t    NO_CHECK   = '0;
  localparam lux_word_t    IDLE_1X    = '{STATUS_WAIT, 40'd0, 16'd0, 16'd0, GAIN_1X, T_100MS};
  localparam sensor_word_t START_WORD = '{ACT_START, 1'b0, GAIN_1X, 16'd0, 16'd0};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  lsal_in_if  in_ch ();
  lsal_out_if out_ch ();

  light_sensor_autorange_lux_top #(
    .MAX_RETRIES(MAX_RETRIES),
    .MAX_ADJUST (MAX_ADJUST)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  logic        busy       = 1'b0;
  logic        cur_gain   = GAIN_1X;
  logic [1:0]  cur_time   = T_100MS;
  logic [3:0]  adjust_cnt = '0;
  logic [2:0]  retry_cnt  = '0;
  logic        cfg_auto   = 1'b0;
  logic        cfg_gain   = GAIN_1X;
  logic [1:0]  cfg_time   = T_100MS;
  logic [15:0] cfg_glass  = 16'(GLASS_RESET);

  lux_word_t lux_expected [$];
  int        mismatches    = 0;
  int        fail_burst    = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  step_row_t directed_rows [25] = '{
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_1X, 16'd123, 16'd45}, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, START_WORD, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, '{ACT_START, 1'b1, GAIN_150X, CNT_SAT, CNT_SAT}, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_1X, 16'd0, 16'd0}, 1'b1,
      '{STATUS_RESULT, 40'd0, 16'd0, 16'd0, GAIN_1X, T_100MS}},
    '{1'b0, KEEP_CFG, START_WORD, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_1X, CNT_SAT, CNT_SAT}, 1'b1,
      '{STATUS_RESULT, 40'd0, CNT_SAT, CNT_SAT, GAIN_1X, T_100MS}},
    '{1'b0, KEEP_CFG, START_WORD, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b0, GAIN_1X, 16'd500, 16'd100}, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b0, GAIN_150X, 16'd0, 16'd0}, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b0, GAIN_1X, 16'hFFFF, 16'hFFFF}, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_150X, 16'd500, 16'd100}, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_150X, 16'd7, 16'd3}, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b0, GAIN_1X, 16'd500, 16'd100}, 1'b1,
      '{STATUS_ABORT, 40'd0, 16'd0, 16'd0, GAIN_1X, T_100MS}},
    '{1'b0, KEEP_CFG, START_WORD, 1'b1, IDLE_1X},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_1X, 16'd1000, 16'd200}, 1'b0, NO_CHECK},
    '{1'b1, '{1'b1, GAIN_150X, T_400MS, 16'hFFFF}, START_WORD, 1'b1,
      '{STATUS_READJ, 40'd0, 16'd0, 16'd0, GAIN_150X, T_400MS}},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_150X, 16'd0, 16'd1}, 1'b0, NO_CHECK},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_150X, 16'd0, 16'd5000}, 1'b0, NO_CHECK},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_150X, 16'd1500, 16'd300}, 1'b0, NO_CHECK},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_150X, CNT_SAT, CNT_SAT}, 1'b0, NO_CHECK},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_150X, 16'd5000, 16'd4000}, 1'b0, NO_CHECK},
    '{1'b1, '{1'b1, GAIN_1X, T_200MS, 16'd1}, START_WORD, 1'b1,
      '{STATUS_READJ, 40'd0, 16'd0, 16'd0, GAIN_1X, T_200MS}},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_1X, 16'd50, 16'd10}, 1'b0, NO_CHECK},
    '{1'b1, '{1'b1, GAIN_1X, T_50MS, 16'd256}, START_WORD, 1'b1,
      '{STATUS_READJ, 40'd0, 16'd0, 16'd0, GAIN_1X, T_50MS}},
    '{1'b0, KEEP_CFG, '{ACT_SAMPLE, 1'b1, GAIN_1X, 16'd30000, 16'd30000}, 1'b0, NO_CHECK}
  };

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned itime_ms(input logic [1:0] t);
    case (t)
      T_100MS: return 100;
      T_50MS:  return 50;
      T_200MS: return 200;
      default: return 400;
    endcase
  endfunction

  function automatic logic [63:0] illuminance_q8(input logic [15:0] c0, input logic [15:0] c1,
                                                 input logic g, input logic [1:0] t);
    logic [63:0] x0, x1, s, kval, a, b;
    x0 = 64'(c0);
    x1 = 64'(c1);
    s = x0 + x1;
    if (c0 == CNT_SAT || c1 == CNT_SAT || s == 0) return '0;
    if (100 * x1 < 45 * s) begin
      kval = 17743 * x0 + 11059 * x1;
    end else begin
      if (100 * x1 < 64 * s) begin
        a = 37725 * x0;
        b = 13363 * x1;
      end else if (100 * x1 < 85 * s) begin
        a = 16903 * x0;
        b = 1693 * x1;
      end else begin
        a = '0;
        b = '0;
      end
      kval = (a > b) ? a - b : '0;
    end
    return (64'(cfg_glass) * kval) /
           (64'((g == GAIN_150X) ? 150 : 1) * itime_ms(t) * 100);
  endfunction

  function automatic int ladder_slot(input logic g, input logic [1:0] t);
    for (int i = 0; i < LADDER_RUNGS; i++) begin
      if (LADDER_GAIN[i] == g && LADDER_TIME[2*i +: 2] == t) return i;
    end
    return -1;
  endfunction

  function automatic lux_word_t range_step(input sensor_word_t w);
    lux_word_t   r;
    logic [63:0] lux;
    logic [15:0] c0, c1;
    int          idx, nidx;
    r = '0;
    r.status = STATUS_WAIT;
    c0 = w.vis;
    c1 = w.ir;
    nidx = -1;
    if (w.action == ACT_START) begin
      if (!busy) begin
        busy = 1'b1;
        cur_gain = cfg_gain;
        cur_time = cfg_time;
        adjust_cnt = '0;
        if (cfg_auto) r.status = STATUS_READJ;
      end
    end else if (busy) begin
      if (!w.new_data || w.rgain != cur_gain) begin
        if (retry_cnt >= MAX_RETRIES) begin
          retry_cnt = '0;
          busy = 1'b0;
          r.status = STATUS_ABORT;
        end else begin
          retry_cnt++;
        end
      end else begin
        retry_cnt = '0;
        lux = illuminance_q8(c0, c1, cur_gain, cur_time);
        if (!cfg_auto || adjust_cnt > MAX_ADJUST) begin
          if (cfg_auto && adjust_cnt != 4'hF) adjust_cnt++;
        end else begin
          if (adjust_cnt != 4'hF) adjust_cnt++;
          if (cur_gain == GAIN_150X && c0 == 0) begin
            if (c1 == 1) begin
              c0 = CNT_SAT;
              c1 = CNT_SAT;
            end else if (c1 > IR_FIX_MIN) begin
              c0 = CNT_SAT;
            end
          end
          idx = ladder_slot(cur_gain, cur_time);
          if (c0 <= ((cur_gain == GAIN_150X) ? UP_THR_150X : UP_THR_1X) ||
              (cur_gain == GAIN_1X && lux < LUX_UP_MIN)) begin
            if (idx >= 0 && idx < LADDER_RUNGS - 1) nidx = idx + 1;
          end else if (c0 >= DOWN_THR || c1 >= DOWN_THR) begin
            if (idx > 0) nidx = idx - 1;
          end
        end
        if (nidx >= 0) begin
          cur_gain = LADDER_GAIN[nidx];
          cur_time = LADDER_TIME[2*nidx +: 2];
          r.status = STATUS_READJ;
        end else begin
          busy = 1'b0;
          r.status = STATUS_RESULT;
        end
        r.lux = lux[39:0];
        r.vis = c0;
        r.ir = c1;
      end
    end
    r.gain = cur_gain;
    r.tcode = cur_time;
    return r;
  endfunction

  function automatic sensor_word_t next_sensor_word();
    sensor_word_t w;
    int           pick;
    pick = $urandom_range(99);
    w.action = ACT_SAMPLE;
    w.new_data = 1'b1;
    w.rgain = cur_gain;
    w.vis = 16'($urandom);
    w.ir = 16'($urandom);
    if (busy && fail_burst == 0 && pick < 3) fail_burst = $urandom_range(7, 4);
    if (!busy) begin
      if (pick < 88) begin
        w.action = ACT_START;
      end else begin
        w.new_data = 1'($urandom);
        w.rgain = 1'($urandom);
      end
    end else if (fail_burst > 0 || pick < 10) begin
      if (fail_burst > 0) fail_burst--;
      if ($urandom_range(1) == 1) begin
        w.new_data = 1'b0;
        w.rgain = 1'($urandom);
      end else begin
        w.rgain = ~cur_gain;
      end
    end else if (pick < 14) begin
      w.action = ACT_START;
    end else begin
      case ($urandom_range(7))
        0: begin
          w.vis = 16'($urandom_range(100));
          w.ir = 16'($urandom_range(100));
        end
        1: begin
          w.vis = 16'($urandom_range(2000));
          w.ir = 16'($urandom_range(2000));
        end
        2: w.vis = 16'($urandom_range(65535, 25000));
        3: ;
        4: begin
          w.vis = '0;
          w.ir = 16'($urandom_range(3));
        end
        5: begin
          w.vis = '0;
          w.ir = 16'($urandom_range(65535, 999));
        end
        6: begin
          w.vis = 16'($urandom_range(30000, 2000));
          w.ir = 16'((32'(w.vis) * $urandom_range(120)) / 100);
        end
        default: begin
          if ($urandom_range(1) == 1) w.vis = CNT_SAT;
          else w.ir = CNT_SAT;
        end
      endcase
    end
    return w;
  endfunction

  function automatic void note_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_word(input sensor_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= w.action;
    in_ch.new_data      <= w.new_data;
    in_ch.reported_gain <= w.rgain;
    in_ch.visible_count <= w.vis;
    in_ch.infrared_count <= w.ir;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (lux_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_ranging(input range_cfg_t c);
    logic [1:0] reg_idx;
    for (int k = 0; k < 4; k++) begin
      reg_idx = 2'(k);
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= reg_idx;
      case (reg_idx)
        CFG_AUTO_MODE:  cfg_data_i <= 16'(c.auto_on);
        CFG_START_GAIN: cfg_data_i <= 16'(c.gain);
        CFG_START_TIME: cfg_data_i <= 16'(c.tcode);
        default:        cfg_data_i <= c.glass;
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_auto = c.auto_on;
    cfg_gain = c.gain;
    cfg_time = c.tcode;
    cfg_glass = c.glass;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    lux_word_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.lux_q8, out_ch.visible_out, out_ch.infrared_out,
              out_ch.gain_code, out_ch.time_code};
      if (lux_expected.size() == 0) begin
        $display("%0t: word expected none got status %0d lux %0h", $time, got.status, got.lux);
        mismatches++;
      end else begin
        want = lux_expected.pop_front();
        note_field("status", want.status, got.status);
        note_field("lux_q8", want.lux, got.lux);
        note_field("visible_out", want.vis, got.vis);
        note_field("infrared_out", want.ir, got.ir);
        note_field("gain_code", want.gain, got.gain);
        note_field("time_code", want.tcode, got.tcode);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    step_row_t    row;
    sensor_word_t w;
    lux_word_t    predicted;
    range_cfg_t   phase_cfg;
    int           counted, cfg_phase, next_cfg_at;
    logic         ignored;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_AUTO_MODE;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_START;
    in_ch.new_data = 1'b0;
    in_ch.reported_gain = GAIN_1X;
    in_ch.visible_count = '0;
    in_ch.infrared_count = '0;
    send_idle_pct = 38;
    recv_idle_pct = 47;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.load_cfg) begin
        wait_drained();
        program_ranging(row.cfg);
      end
      send_word(row.word);
      predicted = range_step(row.word);
      lux_expected.push_back(row.typed ? row.want : predicted);
    end

    counted = 0;
    cfg_phase = 0;
    next_cfg_at = 0;
    while (counted < RAND_WORDS) begin
      if (counted >= next_cfg_at) begin
        case (cfg_phase)
          0: phase_cfg = '{1'b1, GAIN_1X, T_50MS, 16'd256};
          1: phase_cfg = '{1'b1, GAIN_150X, T_400MS, 16'hFFFF};
          2: phase_cfg = '{1'b1, GAIN_1X, T_100MS, 16'd1};
          3: phase_cfg = '{1'b0, GAIN_150X, T_200MS, 16'($urandom_range(65535, 1))};
          4: phase_cfg = '{1'b1, GAIN_150X, T_100MS, 16'($urandom_range(65535, 1))};
          5: phase_cfg = '{1'b1, GAIN_1X, T_200MS, 16'($urandom_range(65535, 1))};
          default: phase_cfg = '{($urandom_range(99) < 80), 1'($urandom), 2'($urandom),
                                 16'($urandom_range(65535, 1))};
        endcase
        wait_drained();
        program_ranging(phase_cfg);
        cfg_phase++;
        next_cfg_at += CFG_SPAN;
      end
      if (counted < RAND_WORDS / 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 47;
      end else if (counted < 2 * RAND_WORDS / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      w = next_sensor_word();
      ignored = (w.action == ACT_START && busy) || (w.action == ACT_SAMPLE && !busy);
      send_word(w);
      lux_expected.push_back(range_step(w));
      if (!ignored) counted++;
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
